### src/pwms_pkg.sv
// package: payload types, cell control struct and constants of the window scorer
`default_nettype none

package pwms_pkg;

    localparam int ADDR_W = 3;
    localparam logic [ADDR_W-1:0] ADDR_WINDOW_LENGTH = 3'd0;
    localparam int WLEN_W = 6;
    localparam logic [WLEN_W-1:0] WLEN_RESET = 6'd32;

    localparam int SCORE_W = 21;
    localparam int INDEX_W = 16;
    localparam int SCORE_MAX = 1048575;
    localparam int SCORE_MIN = -1048576;

    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_SCAN = 1'b1;

    typedef struct packed {
        logic               action;
        logic [4:0]         position;
        logic [1:0]         symbol;
        logic signed [15:0] weight;
        logic               start_req;
    } t_in;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [INDEX_W-1:0]        start_index;
    } t_out;

    typedef struct packed {
        logic       load;
        logic       scan;
        logic       start;
        logic [4:0] position;
        logic [1:0] symbol;
    } t_cell_ctl;

endpackage

`default_nettype wire

### src/weight_matrix_window_scorer_top.sv
// top level: cell row, window bookkeeping, result stage and config port
//
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_ready    i_in_data  (t_in)
// out       output     o_out_valid / i_out_ready  o_out_data (t_out)
// config    input      psel, penable, pwrite      paddr, pwdata / prdata
//
// one item per cycle while the output is not stalled; every cell adds one table weight to its left neighbor's sum
// a result for an accepted base is registered in the sum row and the pending stage, then in the output register
// synchronous active-low reset clears all sums, counters and window_length to 32
// a stalled output holds one result in the output register and one in the sum row
`default_nettype none

module weight_matrix_window_scorer_top #(
    parameter int MAX_WINDOW    = 32,
    parameter int ALPHABET_SIZE = 4,
    parameter int WEIGHT_BITS   = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire pwms_pkg::t_in               i_in_data,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output pwms_pkg::t_out                   o_out_data,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire [pwms_pkg::ADDR_W-1:0]       paddr,
    input  wire [31:0]                       pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    localparam int SUM_RAW = WEIGHT_BITS + $clog2(MAX_WINDOW + 1) + 1;
    localparam int SUM_W   = (SUM_RAW > pwms_pkg::SCORE_W) ? SUM_RAW : pwms_pkg::SCORE_W + 1;
    localparam int LEN_W   = $clog2(MAX_WINDOW + 1);
    localparam int SEL_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam logic signed [SUM_W-1:0] L_MAX = SUM_W'(pwms_pkg::SCORE_MAX);
    localparam logic signed [SUM_W-1:0] L_MIN = SUM_W'(pwms_pkg::SCORE_MIN);

    logic [pwms_pkg::WLEN_W-1:0]  r_wlen;
    logic [pwms_pkg::INDEX_W-1:0] r_bases;
    logic [pwms_pkg::INDEX_W-1:0] n_bases;
    logic [LEN_W-1:0]             r_fill;
    logic [LEN_W-1:0]             n_fill;
    logic [LEN_W-1:0]             w_fill_base;
    logic [LEN_W-1:0]             w_act_len;
    logic                         r_s1_valid;
    logic [pwms_pkg::INDEX_W-1:0] r_s1_idx;
    logic [SEL_W-1:0]             r_s1_sel;
    logic                         r_out_valid;
    pwms_pkg::t_out               r_out;
    logic                         w_in_acc;
    logic                         w_scan;
    logic                         w_start;
    logic                         w_s1_move;
    logic                         w_emit;
    logic                         w_cfg_wr;
    pwms_pkg::t_cell_ctl          w_ctl;
    logic signed [WEIGHT_BITS-1:0] w_load_weight;
    logic signed [SUM_W-1:0]      w_sum [MAX_WINDOW];
    logic signed [SUM_W-1:0]      w_pick;
    logic signed [pwms_pkg::SCORE_W-1:0] w_sat;

    // config port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr == pwms_pkg::ADDR_WINDOW_LENGTH);
    assign prdata   = (paddr == pwms_pkg::ADDR_WINDOW_LENGTH) ? 32'(r_wlen) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen <= pwms_pkg::WLEN_RESET;
        end else if (w_cfg_wr) begin
            r_wlen <= pwdata[pwms_pkg::WLEN_W-1:0];
        end
    end

    always_comb begin
        if (r_wlen == '0) begin
            w_act_len = LEN_W'(1);
        end else if (32'(r_wlen) > MAX_WINDOW) begin
            w_act_len = LEN_W'(MAX_WINDOW);
        end else begin
            w_act_len = LEN_W'(r_wlen);
        end
    end

    // input handshake and cell control
    assign w_s1_move  = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || w_s1_move;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_scan     = w_in_acc && (i_in_data.action == pwms_pkg::ACTION_SCAN);
    assign w_start    = w_scan && i_in_data.start_req;

    assign w_ctl.load     = w_in_acc && (i_in_data.action == pwms_pkg::ACTION_LOAD);
    assign w_ctl.scan     = w_scan;
    assign w_ctl.start    = w_start;
    assign w_ctl.position = i_in_data.position;
    assign w_ctl.symbol   = i_in_data.symbol;
    assign w_load_weight  = WEIGHT_BITS'(i_in_data.weight);

    // cell row
    for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
        logic signed [SUM_W-1:0] w_left;
        if (j == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_next
            assign w_left = w_sum[j-1];
        end
        pwms_cell #(
            .WEIGHT_BITS   (WEIGHT_BITS),
            .ALPHABET_SIZE (ALPHABET_SIZE),
            .SUM_W         (SUM_W),
            .POS           (j)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_weight (w_load_weight),
            .i_sum    (w_left),
            .o_sum    (w_sum[j])
        );
    end

    // window bookkeeping
    always_comb begin
        n_bases     = w_start ? pwms_pkg::INDEX_W'(1) : r_bases + pwms_pkg::INDEX_W'(1);
        w_fill_base = w_start ? '0 : r_fill;
        n_fill      = (32'(w_fill_base) < MAX_WINDOW) ? w_fill_base + LEN_W'(1) : w_fill_base;
        w_emit      = (n_fill >= w_act_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bases     <= '0;
            r_fill      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_scan) begin
                r_bases <= n_bases;
                r_fill  <= n_fill;
            end
            if (w_in_acc) begin
                r_s1_valid <= w_scan && w_emit;
            end else if (w_s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_scan) begin
            r_s1_idx <= n_bases - pwms_pkg::INDEX_W'(w_act_len);
            r_s1_sel <= SEL_W'(w_act_len - LEN_W'(1));
        end
    end

    // result stage
    always_comb begin
        w_pick = w_sum[r_s1_sel];
        if (w_pick > L_MAX) begin
            w_sat = pwms_pkg::SCORE_W'(pwms_pkg::SCORE_MAX);
        end else if (w_pick < L_MIN) begin
            w_sat = pwms_pkg::SCORE_W'(pwms_pkg::SCORE_MIN);
        end else begin
            w_sat = pwms_pkg::SCORE_W'(w_pick);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_out.score       <= w_sat;
            r_out.start_index <= r_s1_idx;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_s1_move |=> r_s1_valid)
        else $error("pending result lost");

    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_move |=> r_out_valid)
        else $error("pending result not moved to output");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.load |=> !r_s1_valid)
        else $error("load produced a result");

    a_start_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> (r_bases == pwms_pkg::INDEX_W'(1)) && (r_fill == LEN_W'(1)))
        else $error("start did not restart the sequence");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= MAX_WINDOW)
        else $error("fill count beyond window depth");

endmodule

`default_nettype wire

### src/pwms_cell.sv
// one matrix position: its weights and the running window sum it passes on
`default_nettype none

module pwms_cell #(
    parameter int WEIGHT_BITS   = 16,
    parameter int ALPHABET_SIZE = 4,
    parameter int SUM_W         = 22,
    parameter int POS           = 0
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire pwms_pkg::t_cell_ctl      i_ctl,
    input  wire logic signed [WEIGHT_BITS-1:0] i_weight,
    input  wire logic signed [SUM_W-1:0]  i_sum,
    output logic signed [SUM_W-1:0]       o_sum
);

    logic signed [WEIGHT_BITS-1:0] r_w [ALPHABET_SIZE];
    logic signed [SUM_W-1:0]       r_sum;
    logic signed [SUM_W-1:0]       n_sum;
    logic signed [SUM_W-1:0]       w_sel;
    logic signed [SUM_W-1:0]       w_left;

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < ALPHABET_SIZE; a++) begin
            if (i_ctl.load && (32'(i_ctl.position) == POS) && (32'(i_ctl.symbol) == a)) begin
                r_w[a] <= i_weight;
            end
        end
    end

    always_comb begin
        w_sel = '0;
        for (int a = 0; a < ALPHABET_SIZE; a++) begin
            if (32'(i_ctl.symbol) == a) begin
                w_sel = SUM_W'(r_w[a]);
            end
        end
        w_left = i_ctl.start ? '0 : i_sum;
        n_sum  = w_left + w_sel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctl.scan) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

`default_nettype wire

### bench/tb.sv
// testbench: window scorer driven with weight loads and base scans, checked against a predictor
`timescale 1ns / 1ps

module tb;

    localparam int ROWS = 32;
    localparam int SYMS = 4;

    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_TOGGLE} t_rx_mode;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    pwms_pkg::t_in      i_in_data = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    pwms_pkg::t_out     o_out_data;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [pwms_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    always #4 i_clk = ~i_clk;

    weight_matrix_window_scorer_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // predictor state
    logic signed [15:0] pwm_weight [ROWS][SYMS];
    int                 row_sum [ROWS];
    logic [15:0]        base_count = '0;
    int                 seq_fill = 0;
    logic [pwms_pkg::WLEN_W-1:0] wl_reg = pwms_pkg::WLEN_RESET;

    pwms_pkg::t_out window_scores[$];
    pwms_pkg::t_in  pending_items[$];
    int   queued_cnt = 0;
    int   taken_cnt = 0;
    int   load_cnt = 0;
    int   scan_cnt = 0;
    int   checked_cnt = 0;
    int   wl_writes = 0;
    int   err_cnt = 0;

    initial begin
        foreach (row_sum[j]) row_sum[j] = 0;
    end

    function automatic void advance_scorer(input pwms_pkg::t_in it);
        int             span;
        int             total;
        pwms_pkg::t_out r;
        if (it.action == pwms_pkg::ACTION_LOAD) begin
            pwm_weight[it.position][it.symbol] = it.weight;
            load_cnt++;
            return;
        end
        scan_cnt++;
        if (it.start_req) begin
            foreach (row_sum[j]) row_sum[j] = 0;
            base_count = '0;
            seq_fill = 0;
        end
        for (int j = ROWS - 1; j >= 0; j--) begin
            row_sum[j] = ((j > 0) ? row_sum[j-1] : 0) + int'(pwm_weight[j][it.symbol]);
        end
        base_count = base_count + 16'd1;
        if (seq_fill < ROWS) seq_fill++;
        span = (wl_reg == 0) ? 1 : ((wl_reg > ROWS) ? ROWS : int'(wl_reg));
        if (seq_fill < span) return;
        total = row_sum[span-1];
        if (total > pwms_pkg::SCORE_MAX) total = pwms_pkg::SCORE_MAX;
        if (total < pwms_pkg::SCORE_MIN) total = pwms_pkg::SCORE_MIN;
        r.score = total[pwms_pkg::SCORE_W-1:0];
        r.start_index = base_count - 16'(span);
        window_scores.push_back(r);
    endfunction

    function automatic logic signed [15:0] pick_weight();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return -16'sh8000;
            2: return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void queue_load(input int pos, input int sym,
                                       input logic signed [15:0] w, input bit st);
        pwms_pkg::t_in it;
        it.action = pwms_pkg::ACTION_LOAD;
        it.position = 5'(pos);
        it.symbol = 2'(sym);
        it.weight = w;
        it.start_req = st;
        pending_items.push_back(it);
        queued_cnt++;
    endfunction

    function automatic void queue_scan(input int sym, input bit st);
        pwms_pkg::t_in it;
        it.action = pwms_pkg::ACTION_SCAN;
        it.position = 5'($urandom_range(0, 31));
        it.symbol = 2'(sym);
        it.weight = 16'($urandom);
        it.start_req = st;
        pending_items.push_back(it);
        queued_cnt++;
    endfunction

    task automatic wait_idle();
        do @(posedge i_clk); while (taken_cnt != queued_cnt || window_scores.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_window_length(input int v);
        wait_idle();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= pwms_pkg::ADDR_WINDOW_LENGTH;
        pwdata <= 32'(v & 6'h3f);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        wl_reg = pwms_pkg::WLEN_W'(v);
        wl_writes++;
    endtask

    // sender: bursts of transfers with gaps between them
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge i_clk) begin : drive_items
        pwms_pkg::t_in nxt;
        logic          nxt_valid;
        nxt = i_in_data;
        nxt_valid = i_in_valid;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                advance_scorer(i_in_data);
                taken_cnt++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_items.size() > 0) begin
                    nxt = pending_items.pop_front();
                    nxt_valid = 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
        i_in_valid <= nxt_valid;
        i_in_data <= nxt;
    end

    // receiver: stall pattern switches at random among open, light, heavy and toggling modes
    t_rx_mode rx_mode = RX_OPEN;
    int       mode_left = 0;

    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 200);
        end else begin
            mode_left--;
        end
        case (rx_mode)
            RX_OPEN:  i_out_ready <= 1'b1;
            RX_LIGHT: i_out_ready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: i_out_ready <= ($urandom_range(0, 7) == 0);
            default:  i_out_ready <= ~i_out_ready;
        endcase
    end

    always @(posedge i_clk) begin : check_results
        pwms_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (window_scores.size() == 0) begin
                $error("unexpected result transfer: score %0d start_index %0d",
                       o_out_data.score, o_out_data.start_index);
                err_cnt++;
            end else begin
                want = window_scores.pop_front();
                checked_cnt++;
                if (o_out_data.score !== want.score) begin
                    $error("score: expected %0d, got %0d", want.score, o_out_data.score);
                    err_cnt++;
                end
                if (o_out_data.start_index !== want.start_index) begin
                    $error("start_index: expected %0d, got %0d",
                           want.start_index, o_out_data.start_index);
                    err_cnt++;
                end
            end
        end
    end

    initial begin : stimulus
        int wl;
        int seq_left;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // table fill, symbol 0 at the top weight and symbol 1 at the bottom
        for (int p = 0; p < ROWS; p++) begin
            for (int s = 0; s < SYMS; s++) begin
                case (s)
                    0: queue_load(p, s, 16'sh7fff, $urandom_range(0, 1));
                    1: queue_load(p, s, -16'sh8000, $urandom_range(0, 1));
                    default: queue_load(p, s, 16'($urandom), $urandom_range(0, 1));
                endcase
            end
        end

        // full-length windows at reset length: largest and smallest score
        queue_scan(0, 1);
        repeat (32) queue_scan(0, 0);
        queue_load(5, 2, 16'sh0100, 1'b1);
        queue_scan(1, 0);
        queue_scan(1, 1);
        repeat (31) queue_scan(1, 0);

        set_window_length(1);
        queue_scan(0, 1);
        for (int s = 0; s < SYMS; s++) queue_scan(s, 0);
        set_window_length(0);
        queue_scan(3, 1);
        queue_scan(2, 0);
        set_window_length(63);
        queue_scan(2, 1);
        repeat (33) queue_scan($urandom_range(0, 3), 0);
        set_window_length(40);
        repeat (3) queue_scan($urandom_range(0, 3), 0);

        // length changed in the middle of a sequence
        set_window_length(32);
        queue_scan(1, 1);
        repeat (9) queue_scan($urandom_range(0, 3), 0);
        set_window_length(5);
        repeat (2) queue_scan($urandom_range(0, 3), 0);
        set_window_length(20);
        repeat (12) queue_scan($urandom_range(0, 3), 0);
        set_window_length(8);
        repeat (4) queue_scan($urandom_range(0, 3), 0);

        for (int ph = 0; ph < 8; ph++) begin
            case ($urandom_range(0, 9))
                0: wl = 0;
                1: wl = $urandom_range(33, 63);
                2: wl = 1;
                3: wl = 32;
                default: wl = $urandom_range(1, 32);
            endcase
            set_window_length(wl);
            seq_left = 0;
            repeat (110) begin
                if ($urandom_range(0, 9) == 0) begin
                    queue_load($urandom_range(0, 31), $urandom_range(0, 3), pick_weight(),
                               $urandom_range(0, 1));
                end else begin
                    if (seq_left == 0) begin
                        if ($urandom_range(0, 7) == 0) seq_left = $urandom_range(1, 6);
                        else seq_left = $urandom_range((wl > 32) ? 32 : wl, 70);
                        queue_scan($urandom_range(0, 3), 1'b1);
                    end else begin
                        queue_scan($urandom_range(0, 3), 1'b0);
                    end
                    seq_left--;
                end
            end
        end

        wait_idle();
        $display("covered %0d weight loads and %0d scanned bases, %0d window scores compared",
                 load_cnt, scan_cnt, checked_cnt);
        $display("window_length written %0d times, out-of-range values included",
                 wl_writes);
        if (err_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
